// File: hdl/circular_deque_macros.svh
// assertion macros for the circular deque block
// expects i_clk and i_rst_n in the scope of use
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// property holds at every edge outside reset
`define CD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/cd_pkg.sv
// shared types and constants for the circular deque block
// no dependencies
package cd_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_DUMP       = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } t_cell_cmd;

endpackage

// File: hdl/cd_cell.sv
// one storage cell of the deque chain
// depends on cd_pkg for the cell command type and data width
module cd_cell (
    input  logic                                i_clk,
    input  cd_pkg::t_cell_cmd                   i_cmd,
    input  logic signed [cd_pkg::DATA_W-1:0]    i_left,
    input  logic signed [cd_pkg::DATA_W-1:0]    i_right,
    input  logic signed [cd_pkg::DATA_W-1:0]    i_load,
    output logic signed [cd_pkg::DATA_W-1:0]    o_data
);

    logic signed [cd_pkg::DATA_W-1:0] r_data;
    logic signed [cd_pkg::DATA_W-1:0] n_data;

    always_comb begin
        case (i_cmd)
            cd_pkg::CELL_FROM_LEFT:  n_data = i_left;
            cd_pkg::CELL_FROM_RIGHT: n_data = i_right;
            cd_pkg::CELL_LOAD:       n_data = i_load;
            default:                 n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: hdl/circular_deque.sv
// top level of the circular deque: control, result register and the cell chain
// depends on cd_pkg, cd_cell and circular_deque_macros.svh
//
// Bounded deque of DEPTH signed 32-bit values held in a row of cells, front
// entry in cell 0 outside a dump. Push front and pop front shift the whole row
// one cell; push back writes the cell at the fill count; pop back reads the cell
// just below it. A push or pop is taken while busy is low, and its result
// appears on the result ports in the next cycle, so these items can be issued
// every cycle while no dump runs. A dump of a non-empty deque raises busy and
// rotates the row one cell per cycle, giving one entry per cycle from front to
// back; no item is taken while busy is high, and busy falls with the last result.
// Results are shown for a single cycle under o_strobe and cannot be held off.
// Modes 5..7 are ignored and give no result.
`include "circular_deque_macros.svh"

module circular_deque (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_mode,
    input  logic signed [cd_pkg::DATA_W-1:0]    i_value,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic signed [cd_pkg::DATA_W-1:0]    o_value_res,
    output logic                                o_last
);

    logic                                   r_busy;
    logic [cd_pkg::CNT_W-1:0]               r_occ;
    logic [cd_pkg::CNT_W-1:0]               r_cnt;
    logic                                   r_strobe;
    cd_pkg::t_status                        r_status;
    logic signed [cd_pkg::DATA_W-1:0]       r_value;
    logic                                   r_last;

    logic                                   accept;
    cd_pkg::t_mode                          mode;
    logic                                   full;
    logic                                   empty;
    logic                                   single;
    logic                                   dump_done;
    logic [cd_pkg::CNT_W-1:0]               w_occ_m1;
    logic [cd_pkg::IDX_W-1:0]               w_back_idx;
    logic signed [cd_pkg::DATA_W-1:0]       w_load;
    logic signed [cd_pkg::DATA_W-1:0]       w_data [cd_pkg::DEPTH];
    cd_pkg::t_cell_cmd                      cmds   [cd_pkg::DEPTH];

    assign accept     = start && !r_busy;
    assign mode       = cd_pkg::t_mode'(i_mode);
    assign full       = (r_occ == cd_pkg::CNT_W'(cd_pkg::DEPTH));
    assign empty      = (r_occ == '0);
    assign w_occ_m1   = r_occ - cd_pkg::CNT_W'(1);
    assign w_back_idx = w_occ_m1[cd_pkg::IDX_W-1:0];
    assign w_load     = r_busy ? w_data[0] : i_value;
    assign single     = accept && (i_mode < 3'(cd_pkg::MODE_DUMP));
    assign dump_done  = r_busy && (r_cnt == w_occ_m1);

    // per-cell command decode
    always_comb begin
        for (int k = 0; k < cd_pkg::DEPTH; k++) begin
            cmds[k] = cd_pkg::CELL_HOLD;
            if (r_busy) begin
                if (cd_pkg::CNT_W'(k) == w_occ_m1) begin
                    cmds[k] = cd_pkg::CELL_LOAD;
                end else if (cd_pkg::CNT_W'(k) < w_occ_m1) begin
                    cmds[k] = cd_pkg::CELL_FROM_RIGHT;
                end
            end else if (accept) begin
                case (mode)
                    cd_pkg::MODE_PUSH_FRONT: begin
                        if (!full) begin
                            cmds[k] = (k == 0) ? cd_pkg::CELL_LOAD
                                               : cd_pkg::CELL_FROM_LEFT;
                        end
                    end
                    cd_pkg::MODE_PUSH_BACK: begin
                        if (!full && (cd_pkg::CNT_W'(k) == r_occ)) begin
                            cmds[k] = cd_pkg::CELL_LOAD;
                        end
                    end
                    cd_pkg::MODE_POP_FRONT: begin
                        if (!empty) begin
                            cmds[k] = cd_pkg::CELL_FROM_RIGHT;
                        end
                    end
                    default: cmds[k] = cd_pkg::CELL_HOLD;
                endcase
            end
        end
    end

    // cell chain
    for (genvar g = 0; g < cd_pkg::DEPTH; g++) begin : g_cell
        logic signed [cd_pkg::DATA_W-1:0] left_d;
        logic signed [cd_pkg::DATA_W-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = w_data[g];
        end else begin : g_mid_l
            assign left_d = w_data[g-1];
        end

        if (g == cd_pkg::DEPTH - 1) begin : g_tail
            assign right_d = w_data[g];
        end else begin : g_mid_r
            assign right_d = w_data[g+1];
        end

        cd_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmds[g]),
            .i_left  (left_d),
            .i_right (right_d),
            .i_load  (w_load),
            .o_data  (w_data[g])
        );
    end

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_occ    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_status <= cd_pkg::ST_OK;
            r_value  <= '0;
            r_last   <= 1'b1;
            if (r_busy) begin
                r_strobe <= 1'b1;
                r_value  <= w_data[0];
                r_cnt    <= r_cnt + cd_pkg::CNT_W'(1);
                if (r_cnt == w_occ_m1) begin
                    r_busy <= 1'b0;
                end else begin
                    r_last <= 1'b0;
                end
            end else if (accept) begin
                case (mode)
                    cd_pkg::MODE_PUSH_FRONT, cd_pkg::MODE_PUSH_BACK: begin
                        r_strobe <= 1'b1;
                        if (full) begin
                            r_status <= cd_pkg::ST_FULL;
                        end else begin
                            r_occ <= r_occ + cd_pkg::CNT_W'(1);
                        end
                    end
                    cd_pkg::MODE_POP_FRONT: begin
                        r_strobe <= 1'b1;
                        if (empty) begin
                            r_status <= cd_pkg::ST_EMPTY;
                        end else begin
                            r_value <= w_data[0];
                            r_occ   <= w_occ_m1;
                        end
                    end
                    cd_pkg::MODE_POP_BACK: begin
                        r_strobe <= 1'b1;
                        if (empty) begin
                            r_status <= cd_pkg::ST_EMPTY;
                        end else begin
                            r_value <= w_data[w_back_idx];
                            r_occ   <= w_occ_m1;
                        end
                    end
                    cd_pkg::MODE_DUMP: begin
                        if (empty) begin
                            r_strobe <= 1'b1;
                            r_status <= cd_pkg::ST_EMPTY;
                        end else begin
                            r_busy <= 1'b1;
                            r_cnt  <= '0;
                        end
                    end
                    default: r_strobe <= 1'b0;
                endcase
            end
        end
    end

    assign busy        = r_busy;
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_value_res = r_value;
    assign o_last      = r_last;

    `CD_ASSERT(a_occ_bound, r_occ <= cd_pkg::CNT_W'(cd_pkg::DEPTH), "occupancy above depth")
    `CD_ASSERT(a_busy_nonempty, r_busy |-> (r_occ != '0), "dump running on empty store")
    `CD_ASSERT_NEXT(a_single_result, single, r_strobe && r_last, "push or pop gave no result")
    `CD_ASSERT_NEXT(a_dump_end, dump_done, !r_busy && r_strobe && r_last, "dump end missed")

endmodule
